[sv/cpc_pkg.sv]
// cpc_pkg: shared types and constants for the chen prime checker
// holds the control word layout and the microprogram rom of the sequencer
// depends on nothing
`default_nettype none

package cpc_pkg;

    localparam int unsigned PC_WIDTH    = 5;
    localparam int unsigned PAIR_OFFSET = 2;

    // datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_X,       // take the candidate (gated by the input handshake)
        OP_INIT_D,       // divisor = 2, square = 4
        OP_DIV_START,    // load the remainder unit
        OP_DIV_STEP,     // one restoring step
        OP_NEXT_D,       // divisor + 1, square update
        OP_LOAD_Q,       // x = x + 2, candidate flagged prime
        OP_LOAD_CO,      // keep divisor and cofactor, x = cofactor
        OP_SET_PRIME,    // partner is prime
        OP_SET_SEMI,     // partner is semiprime
        OP_EMIT          // write the result register
    } op_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_X_LT2,
        C_SQ_GT,
        C_DIV_BUSY,
        C_REM_ZERO,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t                 op;
        cond_t               cond;
        logic [PC_WIDTH-1:0] target;
    } ucode_t;

    // partner kind codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PRIME = 2'd1;
    localparam logic [1:0] KIND_SEMI  = 2'd2;

    // jump targets
    localparam logic [PC_WIDTH-1:0] A_IDLE       = 5'd0;
    localparam logic [PC_WIDTH-1:0] A_P_LOOP     = 5'd2;
    localparam logic [PC_WIDTH-1:0] A_P_DIV      = 5'd4;
    localparam logic [PC_WIDTH-1:0] A_P_PASS     = 5'd7;
    localparam logic [PC_WIDTH-1:0] A_Q_LOOP     = 5'd9;
    localparam logic [PC_WIDTH-1:0] A_Q_DIV      = 5'd11;
    localparam logic [PC_WIDTH-1:0] A_Q_FAIL     = 5'd14;
    localparam logic [PC_WIDTH-1:0] A_C_LOOP     = 5'd16;
    localparam logic [PC_WIDTH-1:0] A_C_DIV      = 5'd18;
    localparam logic [PC_WIDTH-1:0] A_PRIME_PART = 5'd21;
    localparam logic [PC_WIDTH-1:0] A_SEMI_PART  = 5'd22;
    localparam logic [PC_WIDTH-1:0] A_OUT_WAIT   = 5'd24;
    localparam logic [PC_WIDTH-1:0] A_EMIT       = 5'd25;

    // microprogram: three trial division passes over p, p+2 and the cofactor
    function automatic ucode_t ucode_rom(input logic [PC_WIDTH-1:0] addr);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE};
        case (addr)
            5'd0:  w = '{op: OP_LOAD_X,     cond: C_NO_INPUT, target: A_IDLE};
            // test p
            5'd1:  w = '{op: OP_INIT_D,     cond: C_X_LT2,    target: A_OUT_WAIT};
            5'd2:  w = '{op: OP_NOP,        cond: C_SQ_GT,    target: A_P_PASS};
            5'd3:  w = '{op: OP_DIV_START,  cond: C_NEVER,    target: A_IDLE};
            5'd4:  w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY, target: A_P_DIV};
            5'd5:  w = '{op: OP_NOP,        cond: C_REM_ZERO, target: A_OUT_WAIT};
            5'd6:  w = '{op: OP_NEXT_D,     cond: C_ALWAYS,   target: A_P_LOOP};
            // test p + 2
            5'd7:  w = '{op: OP_LOAD_Q,     cond: C_NEVER,    target: A_IDLE};
            5'd8:  w = '{op: OP_INIT_D,     cond: C_X_LT2,    target: A_Q_FAIL};
            5'd9:  w = '{op: OP_NOP,        cond: C_SQ_GT,    target: A_PRIME_PART};
            5'd10: w = '{op: OP_DIV_START,  cond: C_NEVER,    target: A_IDLE};
            5'd11: w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY, target: A_Q_DIV};
            5'd12: w = '{op: OP_NOP,        cond: C_REM_ZERO, target: A_Q_FAIL};
            5'd13: w = '{op: OP_NEXT_D,     cond: C_ALWAYS,   target: A_Q_LOOP};
            // test the cofactor
            5'd14: w = '{op: OP_LOAD_CO,    cond: C_NEVER,    target: A_IDLE};
            5'd15: w = '{op: OP_INIT_D,     cond: C_X_LT2,    target: A_OUT_WAIT};
            5'd16: w = '{op: OP_NOP,        cond: C_SQ_GT,    target: A_SEMI_PART};
            5'd17: w = '{op: OP_DIV_START,  cond: C_NEVER,    target: A_IDLE};
            5'd18: w = '{op: OP_DIV_STEP,   cond: C_DIV_BUSY, target: A_C_DIV};
            5'd19: w = '{op: OP_NOP,        cond: C_REM_ZERO, target: A_OUT_WAIT};
            5'd20: w = '{op: OP_NEXT_D,     cond: C_ALWAYS,   target: A_C_LOOP};
            // verdicts
            5'd21: w = '{op: OP_SET_PRIME,  cond: C_ALWAYS,   target: A_OUT_WAIT};
            5'd22: w = '{op: OP_SET_SEMI,   cond: C_ALWAYS,   target: A_OUT_WAIT};
            5'd24: w = '{op: OP_NOP,        cond: C_OUT_FULL, target: A_OUT_WAIT};
            5'd25: w = '{op: OP_EMIT,       cond: C_ALWAYS,   target: A_IDLE};
            default: w = '{op: OP_NOP, cond: C_ALWAYS, target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/chen_prime_checker.sv]
// chen_prime_checker: chen prime test by trial division under microcode control
// depends on cpc_pkg (control word types, microprogram rom, kind codes)
//
// usage
//   input channel: in_valid / in_stall / candidate. a transaction is taken at a
//   rising edge with in_valid high and in_stall low. in_stall is high from the
//   cycle after a transaction until the sequencer is back at its idle step.
//   output channel: out_valid / out_stall and the five result fields, held in
//   an output register. one result transaction per input transaction.
// processing
//   every trial divisor runs the bit-serial restoring remainder unit (one
//   quotient bit per cycle) plus the loop steps of the microprogram. a
//   candidate runs up to three trial division passes (p, p+2, cofactor),
//   each up to sqrt(value) divisors. one candidate is processed at a time.
// reset
//   rst_n clears the step counter and the output valid; the block is idle.
// stall
//   a finished result waits in the output register while out_stall is high;
//   the sequencer holds at its wait step until the slot frees, and the next
//   candidate is accepted while a result still waits.
`default_nettype none

module chen_prime_checker #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_stall,
    input  wire logic [VALUE_WIDTH-1:0] candidate,
    output      logic                   out_valid,
    input  wire logic                   out_stall,
    output      logic                   candidate_is_prime,
    output      logic                   is_chen,
    output      logic [1:0]             partner_kind,
    output      logic [8:0]             factor_small,
    output      logic [16:0]            factor_large
);

    // datapath width holds p + 2
    localparam int unsigned DW = VALUE_WIDTH + 1;
    localparam int unsigned SW = DW + 1;
    localparam int unsigned CW = $clog2(DW + 1);
    localparam int unsigned EW = (DW > 17) ? DW : 17;

    // sequencer
    logic [cpc_pkg::PC_WIDTH-1:0] pc_reg;
    logic [cpc_pkg::PC_WIDTH-1:0] pc_next;
    cpc_pkg::ucode_t              uw;
    logic                         taken;
    logic                         in_accept;
    logic                         out_accept;

    // datapath
    logic [DW-1:0]  x_reg;      // value under test
    logic [DW-1:0]  d_reg;      // trial divisor
    logic [SW-1:0]  sq_reg;     // divisor squared
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  quo_reg;
    logic [CW-1:0]  cnt_reg;
    logic           prime_reg;
    logic [1:0]     kind_reg;
    logic [DW-1:0]  fs_reg;
    logic [DW-1:0]  fl_reg;

    // remainder step
    logic [DW:0]    partial;
    logic [DW+1:0]  diff;
    logic           borrow;

    // result register
    logic           out_valid_reg;
    logic           res_prime_reg;
    logic           res_chen_reg;
    logic [1:0]     res_kind_reg;
    logic [8:0]     res_fs_reg;
    logic [16:0]    res_fl_reg;
    logic [EW-1:0]  fs_ext;
    logic [EW-1:0]  fl_ext;
    logic           is_semi;

    assign uw         = cpc_pkg::ucode_rom(pc_reg);
    assign in_stall   = (pc_reg != cpc_pkg::A_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    // jump condition and next step
    always_comb
    begin
        case (uw.cond)
            cpc_pkg::C_NEVER:    taken = 1'b0;
            cpc_pkg::C_ALWAYS:   taken = 1'b1;
            cpc_pkg::C_NO_INPUT: taken = !in_valid;
            cpc_pkg::C_X_LT2:    taken = (x_reg < DW'(2));
            cpc_pkg::C_SQ_GT:    taken = (sq_reg > {1'b0, x_reg});
            cpc_pkg::C_DIV_BUSY: taken = (cnt_reg != CW'(1));
            cpc_pkg::C_REM_ZERO: taken = (rem_reg == '0);
            cpc_pkg::C_OUT_FULL: taken = out_valid_reg && out_stall;
            default:             taken = 1'b0;
        endcase
        pc_next = taken ? uw.target : pc_reg + cpc_pkg::PC_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= cpc_pkg::A_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // restoring division, one quotient bit per step
    assign partial = {rem_reg, quo_reg[DW-1]};
    assign diff    = {1'b0, partial} - {2'b00, d_reg};
    assign borrow  = diff[DW+1];

    always_ff @(posedge clk)
    begin
        case (uw.op)
            cpc_pkg::OP_LOAD_X:
            begin
                if (in_accept)
                begin
                    x_reg     <= {1'b0, candidate};
                    prime_reg <= 1'b0;
                    kind_reg  <= cpc_pkg::KIND_NONE;
                end
            end
            cpc_pkg::OP_INIT_D:
            begin
                d_reg  <= DW'(2);
                sq_reg <= SW'(4);
            end
            cpc_pkg::OP_DIV_START:
            begin
                rem_reg <= '0;
                quo_reg <= x_reg;
                cnt_reg <= CW'(DW);
            end
            cpc_pkg::OP_DIV_STEP:
            begin
                if (borrow)
                begin
                    rem_reg <= partial[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= diff[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end
                cnt_reg <= cnt_reg - CW'(1);
            end
            cpc_pkg::OP_NEXT_D:
            begin
                // (d+1)^2 = d^2 + 2d + 1
                d_reg  <= d_reg + DW'(1);
                sq_reg <= sq_reg + {d_reg, 1'b1};
            end
            cpc_pkg::OP_LOAD_Q:
            begin
                x_reg     <= x_reg + DW'(cpc_pkg::PAIR_OFFSET);
                prime_reg <= 1'b1;
            end
            cpc_pkg::OP_LOAD_CO:
            begin
                fs_reg <= d_reg;
                fl_reg <= quo_reg;
                x_reg  <= quo_reg;
            end
            cpc_pkg::OP_SET_PRIME: kind_reg <= cpc_pkg::KIND_PRIME;
            cpc_pkg::OP_SET_SEMI:  kind_reg <= cpc_pkg::KIND_SEMI;
            cpc_pkg::OP_EMIT:
            begin
                res_prime_reg <= prime_reg;
                res_chen_reg  <= (kind_reg != cpc_pkg::KIND_NONE);
                res_kind_reg  <= kind_reg;
                res_fs_reg    <= is_semi ? fs_ext[8:0] : 9'd0;
                res_fl_reg    <= is_semi ? fl_ext[16:0] : 17'd0;
            end
            default:
            begin
            end
        endcase
    end

    assign is_semi = (kind_reg == cpc_pkg::KIND_SEMI);
    assign fs_ext  = EW'(fs_reg);
    assign fl_ext  = EW'(fl_reg);

    // output valid: set by the emit step, cleared by a completed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (uw.op == cpc_pkg::OP_EMIT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign candidate_is_prime = res_prime_reg;
    assign is_chen            = res_chen_reg;
    assign partner_kind       = res_kind_reg;
    assign factor_small       = res_fs_reg;
    assign factor_large       = res_fl_reg;

    // emit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == cpc_pkg::OP_EMIT) |-> !out_valid_reg)
        else $error("result register overwritten");

    // a taken candidate keeps the input side stalled next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input not stalled after transaction");

    // the remainder unit never steps past its last bit
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (uw.op == cpc_pkg::OP_DIV_STEP) |-> (cnt_reg != '0))
        else $error("remainder unit stepped with zero count");

    // chen status needs a prime candidate, factors only with a semiprime partner
    a_result_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!res_chen_reg || res_prime_reg)
            && ((res_kind_reg == cpc_pkg::KIND_NONE)
                || (res_kind_reg == cpc_pkg::KIND_PRIME)
                || (res_kind_reg == cpc_pkg::KIND_SEMI))
            && ((res_kind_reg == cpc_pkg::KIND_SEMI) || (res_fs_reg == 9'd0))))
        else $error("inconsistent result fields");

endmodule

`default_nettype wire

[tb/chen_prime_checker_test.sv]
// chen_prime_checker_test: self-checking testbench for the chen prime checker
// predicts every verdict by trial division in a small scoreboard class
// depends on cpc_pkg (kind codes, pair offset) and chen_prime_checker
`timescale 1ns / 1ps

module chen_prime_checker_test;

    localparam int unsigned VW           = 16;
    localparam int unsigned RANDOM_ITEMS = 72;
    localparam int unsigned HOLD_ITEMS   = 8;
    // receiver hold-off, long enough for the block to fill and stall its input
    localparam int unsigned HOLD_CYCLES  = 3000;
    // quiet cycles after the last result
    localparam int unsigned TAIL_CYCLES  = 10000;
    // watchdog: room for ~100 worst-case candidates, several times over
    localparam int unsigned LIMIT_CYCLES = 10_000_000;
    localparam int unsigned REPORT_MAX   = 10;

    // one expected verdict, tagged with the candidate that caused it
    typedef struct {
        logic [VW-1:0] cand;
        logic          prime;
        logic          chen;
        logic [1:0]    kind;
        logic [8:0]    f_small;
        logic [16:0]   f_large;
    } chen_verdict_t;

    class chen_scoreboard;
        chen_verdict_t pending_verdicts[$];
        int unsigned   mismatches;

        // smallest divisor in [2, sqrt(n)], 0 when there is none
        function int unsigned least_factor(input int unsigned n);
            for (int unsigned d = 2; d * d <= n; d++)
            begin
                if (n % d == 0)
                    return d;
            end
            return 0;
        endfunction

        function bit is_prime_value(input int unsigned n);
            return (n >= 2) && (least_factor(n) == 0);
        endfunction

        function chen_verdict_t predict_verdict(input logic [VW-1:0] cand);
            chen_verdict_t v;
            int unsigned   q;
            int unsigned   d;
            v = '{cand: cand, prime: 1'b0, chen: 1'b0, kind: cpc_pkg::KIND_NONE,
                  f_small: '0, f_large: '0};
            if (is_prime_value(cand))
            begin
                v.prime = 1'b1;
                q = int'(cand) + cpc_pkg::PAIR_OFFSET;
                if (is_prime_value(q))
                begin
                    v.chen = 1'b1;
                    v.kind = cpc_pkg::KIND_PRIME;
                end
                else
                begin
                    d = least_factor(q);
                    if (d != 0 && is_prime_value(q / d))
                    begin
                        v.chen    = 1'b1;
                        v.kind    = cpc_pkg::KIND_SEMI;
                        v.f_small = d[8:0];
                        v.f_large = 17'(q / d);
                    end
                end
            end
            return v;
        endfunction

        function void note_candidate(input logic [VW-1:0] cand);
            pending_verdicts.push_back(predict_verdict(cand));
        endfunction

        function void check_verdict(input logic prime, input logic chen,
                                    input logic [1:0] kind, input logic [8:0] f_small,
                                    input logic [16:0] f_large);
            chen_verdict_t exp_v;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display(
                        "unexpected result: prime=%0b chen=%0b kind=%0d small=%0d large=%0d",
                        prime, chen, kind, f_small, f_large);
                return;
            end
            exp_v = pending_verdicts.pop_front();
            if (prime !== exp_v.prime || chen !== exp_v.chen || kind !== exp_v.kind ||
                f_small !== exp_v.f_small || f_large !== exp_v.f_large)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display(
                        "mismatch %0d: expected %0b %0b %0d %0d %0d, got %0b %0b %0d %0d %0d",
                        exp_v.cand, exp_v.prime, exp_v.chen, exp_v.kind,
                        exp_v.f_small, exp_v.f_large,
                        prime, chen, kind, f_small, f_large);
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_stall;
    logic [VW-1:0] candidate;
    logic          out_valid;
    logic          out_stall;
    logic          candidate_is_prime;
    logic          is_chen;
    logic [1:0]    partner_kind;
    logic [8:0]    factor_small;
    logic [16:0]   factor_large;

    chen_scoreboard sb = new();

    // set by the stimulus, picked up by the receiver process
    bit          hold_request;
    int unsigned burst_left;

    // directed candidates: zero and one, the smallest primes, square partners
    // (2 -> 4, 7 -> 9, 23 -> 25), semiprime partners, partners with three
    // factors (43 -> 45, 61 -> 63), single-bit and alternating patterns,
    // all ones and the largest 16-bit prime
    logic [VW-1:0] directed_values [20] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd23,
        16'd43, 16'd61, 16'd89, 16'd251, 16'h8000, 16'h5555, 16'hAAAA,
        16'hFFFE, 16'hFFFF, 16'd65521
    };

    chen_prime_checker #(
        .VALUE_WIDTH(VW)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .candidate          (candidate),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .candidate_is_prime (candidate_is_prime),
        .is_chen            (is_chen),
        .partner_kind       (partner_kind),
        .factor_small       (factor_small),
        .factor_large       (factor_large)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // first prime at or above n, wrapping past the top of the range
    function automatic logic [VW-1:0] prime_at_or_above(input int unsigned n);
        int unsigned k;
        k = n;
        while (!sb.is_prime_value(k))
        begin
            k++;
            if (k > 65535)
                k = 2;
        end
        return k[VW-1:0];
    endfunction

    // offer one candidate and hold it until the transaction is taken;
    // the expectation is noted here so a drain check right after sees it
    task automatic send_candidate(input logic [VW-1:0] value);
        in_valid  <= 1'b1;
        candidate <= value;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_candidate(value);
    endtask

    // sender bursts: random burst length, then a random gap with valid low;
    // a quarter of the bursts follow the last one with no gap at all
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // wait until every expected result has come back
    task automatic wait_drained();
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [VW-1:0] pick;
        int unsigned   roll;
        in_valid     <= 1'b0;
        candidate    <= '0;
        rst_n         = 1'b0;
        hold_request  = 1'b0;
        burst_left    = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed part, then a full pause until all verdicts are back
        foreach (directed_values[i])
        begin
            pace_sender();
            send_candidate(directed_values[i]);
        end
        in_valid <= 1'b0;
        wait_drained();

        // receiver holds off while small candidates keep coming back to back,
        // so the output register fills and the input side stalls
        hold_request = 1'b1;
        repeat (HOLD_ITEMS)
            send_candidate(VW'($urandom_range(0, 255)));
        in_valid <= 1'b0;
        wait_drained();

        // random part: mostly primes, so the partner and cofactor passes run;
        // a few large primes for the longest passes, the rest raw values
        repeat (RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                pick = prime_at_or_above($urandom_range(0, 4095));
            else if (roll < 62)
                pick = prime_at_or_above($urandom_range(4096, 65535));
            else if (roll < 90)
                pick = VW'($urandom_range(0, 65535));
            else
                pick = VW'($urandom_range(0, 63));
            pace_sender();
            send_candidate(pick);
        end
        in_valid <= 1'b0;

        // drain, then stay quiet long enough to catch a stray result
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0)
            $display("chen_prime_checker_test: done, clean");
        else
            $display("chen_prime_checker_test: done, errors");
        $finish;
    end

    // receiver: stall pattern that changes mode every so often, plus the
    // long hold-off on request, counted here in cycles
    initial
    begin
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned stall_mode;
        hold_left  = 0;
        mode_left  = 0;
        stall_mode = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_stall   <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left  = $urandom_range(20, 200);
                end
                mode_left--;
                case (stall_mode)
                    0:       out_stall <= 1'b0;                        // free running
                    1:       out_stall <= ($urandom_range(0, 3) == 0); // light stalls
                    default: out_stall <= ($urandom_range(0, 3) != 0); // heavy stalls
                endcase
            end
        end
    end

    // result monitor: a result transaction is taken with out_valid high and out_stall low
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_verdict(candidate_is_prime, is_chen, partner_kind,
                             factor_small, factor_large);
    end

    // watchdog
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("chen_prime_checker_test: done, errors");
        $finish;
    end

endmodule
